>>> rtl/hsec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsec_pkg;

    // Configuration register.
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Default upper bound on data bits per word.
    localparam int DEF_MAX_DATA_BITS = 16;

    // Operating modes.
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Result status codes.
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CORRECTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;

    // Least r with 2^r >= d + r + 1, capped at seven.
    function automatic int parity_count(input int d);
        int r;
        r = 1;
        for (int i = 0; i < 6; i++)
        begin
            if ((1 << r) < d + r + 1)
            begin
                r = r + 1;
            end
        end
        return r;
    endfunction

    // Codeword length for a given number of data bits.
    function automatic int code_width(input int d);
        return d + parity_count(d);
    endfunction

    // True when a codeword position is a power of two.
    function automatic bit is_pow2(input int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // Data bit index carried at a non-power-of-two codeword position.
    function automatic int data_index(input int p);
        int count;
        count = 0;
        for (int i = 0; i < 7; i++)
        begin
            if ((1 << i) <= p)
            begin
                count = count + 1;
            end
        end
        return p - count - 1;
    endfunction

endpackage

`default_nettype wire

>>> rtl/hsec_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

module hsec_encoder #(
    parameter int MAX_DATA_BITS = hsec_pkg::DEF_MAX_DATA_BITS,
    localparam int CODE_W = hsec_pkg::code_width(MAX_DATA_BITS),
    localparam int LEN_W = $clog2(CODE_W + 1)
) (
    input  wire logic [MAX_DATA_BITS-1:0] data_word,
    input  wire logic [LEN_W-1:0]         code_len,
    output logic      [CODE_W-1:0]        code_word
);
    import hsec_pkg::*;

    localparam int SYN_W = parity_count(MAX_DATA_BITS);

    logic [CODE_W-1:0] placed;
    logic [SYN_W-1:0]  parity;

    // Spread the data bits over the non-power-of-two positions within the length.
    always_comb
    begin
        placed = '0;
        for (int p = 1; p <= CODE_W; p++)
        begin
            if (!is_pow2(p) && (p <= int'(code_len)))
            begin
                placed[p-1] = data_word[data_index(p)];
            end
        end
    end

    // Each parity bit makes its group of positions even.
    always_comb
    begin
        parity = '0;
        for (int i = 0; i < SYN_W; i++)
        begin
            for (int p = 1; p <= CODE_W; p++)
            begin
                if (((p >> i) & 1) != 0)
                begin
                    parity[i] = parity[i] ^ placed[p-1];
                end
            end
        end
    end

    // Drop the parity bits into their power-of-two positions.
    always_comb
    begin
        code_word = placed;
        for (int i = 0; i < SYN_W; i++)
        begin
            code_word[(1 << i) - 1] = parity[i];
        end
    end

endmodule

`default_nettype wire

>>> rtl/hsec_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

module hsec_decoder #(
    parameter int MAX_DATA_BITS = hsec_pkg::DEF_MAX_DATA_BITS,
    localparam int CODE_W = hsec_pkg::code_width(MAX_DATA_BITS),
    localparam int LEN_W = $clog2(CODE_W + 1),
    localparam int SYN_W = hsec_pkg::parity_count(MAX_DATA_BITS)
) (
    input  wire logic [CODE_W-1:0]             received_word,
    input  wire logic [LEN_W-1:0]              code_len,
    output logic      [SYN_W-1:0]              syndrome,
    output logic      [CODE_W-1:0]             corrected_word,
    output logic      [hsec_pkg::STATUS_W-1:0] status
);
    import hsec_pkg::*;

    logic [CODE_W-1:0] rx_masked;
    logic [CODE_W-1:0] flip;

    // Positions past the codeword length read as zero.
    always_comb
    begin
        for (int p = 1; p <= CODE_W; p++)
        begin
            rx_masked[p-1] = received_word[p-1] & (p <= int'(code_len));
        end
    end

    // Syndrome bit i is the parity of all positions with bit i set.
    always_comb
    begin
        syndrome = '0;
        for (int i = 0; i < SYN_W; i++)
        begin
            for (int p = 1; p <= CODE_W; p++)
            begin
                if (((p >> i) & 1) != 0)
                begin
                    syndrome[i] = syndrome[i] ^ rx_masked[p-1];
                end
            end
        end
    end

    // Classify the syndrome.
    always_comb
    begin
        priority if (syndrome == '0)
        begin
            status = STATUS_OK;
        end
        else if (int'(syndrome) > int'(code_len))
        begin
            status = STATUS_RANGE;
        end
        else
        begin
            status = STATUS_CORRECTED;
        end
    end

    // Flip the position the syndrome points at, only for a correctable error.
    always_comb
    begin
        for (int p = 1; p <= CODE_W; p++)
        begin
            flip[p-1] = (status == STATUS_CORRECTED) && (int'(syndrome) == p);
        end
        corrected_word = rx_masked ^ flip;
    end

endmodule

`default_nettype wire

>>> rtl/hamming_sec_encode_decode_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// --------  --------------------  ---------------------------------------------
// command   start / busy          mode, data_word, received_word
// result    done (strobe)         code_word, syndrome, corrected_word, status
// config    cfg_valid / cfg_ready cfg_data (data_length)
//
// A command beat is taken on every cycle; busy stays low and cfg_ready stays high.
// The input register holds the beat while the parity trees settle;
// the result register loads at the next edge and shows the result under done.
// Reset clears the strobes and loads data_length with 16.
// The result is shown for a single cycle under done; the receiver cannot stall it.

module hamming_sec_encode_decode_unit #(
    parameter int MAX_DATA_BITS = hsec_pkg::DEF_MAX_DATA_BITS,
    localparam int CODE_W = hsec_pkg::code_width(MAX_DATA_BITS),
    localparam int SYN_W = hsec_pkg::parity_count(MAX_DATA_BITS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          mode,
    input  wire logic [MAX_DATA_BITS-1:0]      data_word,
    input  wire logic [CODE_W-1:0]             received_word,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [hsec_pkg::CFG_W-1:0]    cfg_data,
    output logic                               done,
    output logic      [CODE_W-1:0]             code_word,
    output logic      [SYN_W-1:0]              syndrome,
    output logic      [CODE_W-1:0]             corrected_word,
    output logic      [hsec_pkg::STATUS_W-1:0] status
);
    import hsec_pkg::*;

    localparam int LEN_W = $clog2(CODE_W + 1);

    logic [CFG_W-1:0]         data_length_reg;
    logic [LEN_W-1:0]         code_len_next;

    logic                     in_valid_reg;
    logic                     mode_reg;
    logic [MAX_DATA_BITS-1:0] data_reg;
    logic [CODE_W-1:0]        rx_reg;
    logic [LEN_W-1:0]         code_len_reg;

    logic [CODE_W-1:0]        enc_code;
    logic [SYN_W-1:0]         dec_syndrome;
    logic [CODE_W-1:0]        dec_corrected;
    logic [STATUS_W-1:0]      dec_status;

    logic                     done_reg;
    logic [CODE_W-1:0]        code_reg;
    logic [SYN_W-1:0]         syndrome_reg;
    logic [CODE_W-1:0]        corrected_reg;
    logic [STATUS_W-1:0]      status_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_length_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            data_length_reg <= cfg_data;
        end
    end

    // Codeword length from the clamped data length.
    always_comb
    begin
        int d;
        d = int'(data_length_reg);
        if (d < 1)
        begin
            d = 1;
        end
        if (d > MAX_DATA_BITS)
        begin
            d = MAX_DATA_BITS;
        end
        code_len_next = LEN_W'(code_width(d));
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            mode_reg     <= mode;
            data_reg     <= data_word;
            rx_reg       <= received_word;
            code_len_reg <= code_len_next;
        end
    end

    hsec_encoder #(
        .MAX_DATA_BITS(MAX_DATA_BITS)
    ) u_encoder (
        .data_word(data_reg),
        .code_len (code_len_reg),
        .code_word(enc_code)
    );

    hsec_decoder #(
        .MAX_DATA_BITS(MAX_DATA_BITS)
    ) u_decoder (
        .received_word (rx_reg),
        .code_len      (code_len_reg),
        .syndrome      (dec_syndrome),
        .corrected_word(dec_corrected),
        .status        (dec_status)
    );

    // Result register; the fields of the mode not in use read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            if (mode_reg == MODE_ENCODE)
            begin
                code_reg      <= enc_code;
                syndrome_reg  <= '0;
                corrected_reg <= '0;
                status_reg    <= STATUS_OK;
            end
            else
            begin
                code_reg      <= '0;
                syndrome_reg  <= dec_syndrome;
                corrected_reg <= dec_corrected;
                status_reg    <= dec_status;
            end
        end
    end

    assign done           = done_reg;
    assign code_word      = code_reg;
    assign syndrome       = syndrome_reg;
    assign corrected_word = corrected_reg;
    assign status         = status_reg;

endmodule

`default_nettype wire

>>> tb/tb_hamming_sec_encode_decode_unit.sv
`timescale 1ns / 1ps

module tb_hamming_sec_encode_decode_unit;

    import hsec_pkg::*;

    localparam int DATA_W = 16;
    localparam int CODE_W = 21;
    localparam int SYN_W = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 104;

    typedef struct packed {
        logic              mode;
        logic [DATA_W-1:0] data;
        logic [CODE_W-1:0] rx;
    } hamming_cmd_t;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [SYN_W-1:0]    syn;
        logic [CODE_W-1:0]   corr;
        logic [STATUS_W-1:0] stat;
    } hamming_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                mode = MODE_ENCODE;
    logic [DATA_W-1:0]   data_word = '0;
    logic [CODE_W-1:0]   received_word = '0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                done;
    logic [CODE_W-1:0]   code_word;
    logic [SYN_W-1:0]    syndrome;
    logic [CODE_W-1:0]   corrected_word;
    logic [STATUS_W-1:0] status;

    // Commands waiting to go out and the outcomes they are due to produce.
    hamming_cmd_t    pending_cmds[$];
    hamming_result_t expected_outcomes[$];

    // Our own copy of the data_length register.
    logic [CFG_W-1:0] length_setting = CFG_RESET;

    int error_count = 0;
    int cycle_count = 0;
    int results_seen = 0;
    int encode_count = 0;
    int clean_count = 0;
    int fixed_count = 0;
    int range_count = 0;
    int settings_used = 0;

    hamming_cmd_t    taken_cmd;
    hamming_result_t awaited;
    hamming_result_t oldest;
    int              burst_left = 8;
    int              gap_left = 0;
    logic            next_start;

    hamming_sec_encode_decode_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .data_word      (data_word),
        .received_word  (received_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .code_word      (code_word),
        .syndrome       (syndrome),
        .corrected_word (corrected_word),
        .status         (status)
    );

    always #5 clk = ~clk;

    // A zero length acts as one, anything past sixteen as sixteen.
    function automatic int data_bits(input logic [CFG_W-1:0] len);
        if (len == 0)
        begin
            return 1;
        end
        if (len > DATA_W)
        begin
            return DATA_W;
        end
        return int'(len);
    endfunction

    // Codeword length: data bits plus the least parity count that fits.
    function automatic int codeword_len(input logic [CFG_W-1:0] len);
        int d;
        int r;
        d = data_bits(len);
        r = 1;
        while ((1 << r) < d + r + 1)
        begin
            r++;
        end
        return d + r;
    endfunction

    // Expected encoder or checker outcome for one command.
    function automatic hamming_result_t hamming_outcome(input hamming_cmd_t c,
                                                        input logic [CFG_W-1:0] len);
        hamming_result_t res;
        int              n;
        int              k;
        int              s;
        logic [31:0]     word;
        logic            par;
        res = '0;
        n = codeword_len(len);
        word = '0;
        if (c.mode == MODE_ENCODE)
        begin
            // Data fills the non-power-of-two positions in rising order.
            k = 0;
            for (int p = 1; p <= n; p++)
            begin
                if ((p & (p - 1)) != 0)
                begin
                    word[p-1] = c.data[k];
                    k++;
                end
            end
            // Each parity bit makes its covered group even.
            for (int i = 0; (1 << i) <= n; i++)
            begin
                par = 1'b0;
                for (int p = 1; p <= n; p++)
                begin
                    if ((p >> i) & 1)
                    begin
                        par ^= word[p-1];
                    end
                end
                word[(1 << i) - 1] = par;
            end
            res.code = word[CODE_W-1:0];
        end
        else
        begin
            // Positions past the codeword length read as zero.
            word = c.rx & ((32'h1 << n) - 1);
            s = 0;
            for (int p = 1; p <= n; p++)
            begin
                if (word[p-1])
                begin
                    s ^= p;
                end
            end
            res.syn = s[SYN_W-1:0];
            res.stat = STATUS_OK;
            if (s > n)
            begin
                res.stat = STATUS_RANGE;
            end
            else if (s != 0)
            begin
                word[s-1] = ~word[s-1];
                res.stat = STATUS_CORRECTED;
            end
            res.corr = word[CODE_W-1:0];
        end
        return res;
    endfunction

    // Random command: mostly valid codewords with zero, one or two flips.
    function automatic hamming_cmd_t random_cmd(input logic [CFG_W-1:0] len);
        hamming_cmd_t    c;
        hamming_result_t enc;
        int              n;
        int              pick;
        logic [31:0]     above;
        n = codeword_len(len);
        c.data = DATA_W'($urandom_range(0, 16'hFFFF));
        c.rx = CODE_W'($urandom_range(0, 21'h1FFFFF));
        c.mode = $urandom_range(0, 1) ? MODE_DECODE : MODE_ENCODE;
        if (c.mode == MODE_DECODE)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 9)
            begin
                enc = hamming_outcome('{MODE_ENCODE, c.data, '0}, len);
                c.rx = enc.code;
                if (pick >= 4)
                begin
                    c.rx[$urandom_range(1, n) - 1] ^= 1'b1;
                end
                if (pick == 8)
                begin
                    c.rx[$urandom_range(1, n) - 1] ^= 1'b1;
                end
                // Junk above the codeword must be dropped by the checker.
                if ($urandom_range(0, 3) == 0)
                begin
                    above = $urandom() & ~((32'h1 << n) - 1);
                    c.rx |= above[CODE_W-1:0];
                end
            end
        end
        return c;
    endfunction

    // Wait until every queued command has gone out and every result has come back.
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || expected_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Write data_length through the configuration channel.
    task automatic write_length(input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        length_setting = value;
        settings_used++;
    endtask

    // Command driver: bursts of beats separated by random gaps.
    always @(posedge clk)
    begin
        if (start && !busy)
        begin
            taken_cmd = pending_cmds.pop_front();
            awaited = hamming_outcome(taken_cmd, length_setting);
            expected_outcomes.push_back(awaited);
            if (taken_cmd.mode == MODE_ENCODE)
            begin
                encode_count++;
            end
            else if (awaited.stat == STATUS_OK)
            begin
                clean_count++;
            end
            else if (awaited.stat == STATUS_CORRECTED)
            begin
                fixed_count++;
            end
            else
            begin
                range_count++;
            end
        end
        next_start = 1'b0;
        if (gap_left > 0)
        begin
            gap_left--;
        end
        else if (pending_cmds.size() != 0)
        begin
            next_start = 1'b1;
            mode <= pending_cmds[0].mode;
            data_word <= pending_cmds[0].data;
            received_word <= pending_cmds[0].rx;
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end
        end
        start <= next_start;
    end

    // Result monitor: every strobed beat is checked against the oldest outcome.
    always @(posedge clk)
    begin
        if (done)
        begin
            results_seen++;
            if (expected_outcomes.size() == 0)
            begin
                error_count++;
                $display("%0t: result with nothing expected, code %h syn %h corr %h status %0d",
                         $time, code_word, syndrome, corrected_word, status);
            end
            else
            begin
                oldest = expected_outcomes.pop_front();
                if (code_word !== oldest.code)
                begin
                    error_count++;
                    $display("%0t: code_word expected %h actual %h",
                             $time, oldest.code, code_word);
                end
                if (syndrome !== oldest.syn)
                begin
                    error_count++;
                    $display("%0t: syndrome expected %h actual %h",
                             $time, oldest.syn, syndrome);
                end
                if (corrected_word !== oldest.corr)
                begin
                    error_count++;
                    $display("%0t: corrected_word expected %h actual %h",
                             $time, oldest.corr, corrected_word);
                end
                if (status !== oldest.stat)
                begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest.stat, status);
                end
            end
        end
    end

    // Watchdog on the overall run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus sequence: reset, directed cases, then random phases per setting.
    initial
    begin
        logic [CFG_W-1:0] phase_lengths[12];
        logic [CODE_W-1:0] clean_word;
        hamming_result_t   clean_res;

        phase_lengths = '{5'd0, 5'd31, 5'd1, 5'd3, 5'd4, 5'd11,
                          5'd12, 5'd26, 5'd15, 5'd16, 5'd0, 5'd0};
        phase_lengths[10] = CFG_W'($urandom_range(0, 31));
        phase_lengths[11] = CFG_W'($urandom_range(0, 31));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases at the reset length of sixteen data bits.
        clean_res = hamming_outcome('{MODE_ENCODE, 16'hA5A5, '0}, length_setting);
        clean_word = clean_res.code;
        pending_cmds.push_back('{MODE_ENCODE, 16'h0000, 21'h000000});
        pending_cmds.push_back('{MODE_ENCODE, 16'hFFFF, 21'h1FFFFF});
        pending_cmds.push_back('{MODE_ENCODE, 16'h0001, 21'h000000});
        pending_cmds.push_back('{MODE_ENCODE, 16'h8000, 21'h0ABCDE});
        pending_cmds.push_back('{MODE_ENCODE, 16'hA5A5, 21'h000000});
        pending_cmds.push_back('{MODE_DECODE, 16'h0000, 21'h000000});
        pending_cmds.push_back('{MODE_DECODE, 16'hFFFF, 21'h1FFFFF});
        pending_cmds.push_back('{MODE_DECODE, 16'h1234, clean_word});
        pending_cmds.push_back('{MODE_DECODE, 16'h0000, clean_word ^ 21'h000001});
        pending_cmds.push_back('{MODE_DECODE, 16'h0000, clean_word ^ 21'h000002});
        pending_cmds.push_back('{MODE_DECODE, 16'h0000, clean_word ^ 21'h000004});
        pending_cmds.push_back('{MODE_DECODE, 16'h0000, clean_word ^ 21'h008000});
        pending_cmds.push_back('{MODE_DECODE, 16'h0000, clean_word ^ 21'h100000});
        // Two errors alias to a third position and get miscorrected.
        pending_cmds.push_back('{MODE_DECODE, 16'h0000, clean_word ^ 21'h000003});
        // Syndromes of 24 and 31 point past a 21-position codeword.
        pending_cmds.push_back('{MODE_DECODE, 16'h0000, 21'h008080});
        pending_cmds.push_back('{MODE_DECODE, 16'h0000, 21'h100200});
        wait_idle();

        // Each phase starts from an idle block with a new length.
        foreach (phase_lengths[i])
        begin
            write_length(phase_lengths[i]);
            if (i == 0)
            begin
                // Short codewords with junk above them at length one.
                pending_cmds.push_back('{MODE_DECODE, 16'hFFFF, 21'h1FFFFF});
                pending_cmds.push_back('{MODE_ENCODE, 16'hFFFE, 21'h000000});
                pending_cmds.push_back('{MODE_ENCODE, 16'hFFFF, 21'h000000});
            end
            for (int j = 0; j < RANDOM_PER_PHASE; j++)
            begin
                pending_cmds.push_back(random_cmd(length_setting));
            end
            wait_idle();
        end

        repeat (6) @(posedge clk);

        $display("Covered %0d results over %0d length settings.",
                 results_seen, settings_used);
        $display("Encodes %0d, clean checks %0d, corrections %0d, out-of-range syndromes %0d.",
                 encode_count, clean_count, fixed_count, range_count);
        if (error_count == 0 && expected_outcomes.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
